### hw/rtl/i2cw_pkg.sv
// Shared types and constants for the I2C codec register writer.
`default_nettype none
package i2cw_pkg;

   localparam int HOLD_W  = 16;
   localparam int DEV_W   = 8;
   localparam int FRAME_W = 24;
   localparam int CSR_W   = 16;

   localparam logic [DEV_W-1:0]  DEV_BYTE_RESET    = 8'h34;
   localparam logic [HOLD_W-1:0] PHASE_TICKS_RESET = 16'd900;

   // register indexes on the csr port
   localparam logic CSR_DEVICE_WRITE_BYTE = 1'b0;
   localparam logic CSR_PHASE_TICKS       = 1'b1;

   // result word of one item
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_released;
      logic       busy_res;
      logic       accepted;
      logic       done_res;
      logic [2:0] ack_fail;
   } result_type;

   // one input word as seen by the sequencer
   typedef struct packed {
      logic       command;
      logic [6:0] reg_addr;
      logic [8:0] reg_data;
      logic       sda_in;
   } item_type;

endpackage
`default_nettype wire

### hw/rtl/i2cw_sequencer.sv
// Bus phase sequencer: line levels, hold counter, frame shifter and ack flags.
`default_nettype none
module i2cw_sequencer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire i2cw_pkg::item_type         item,
   input  wire logic [i2cw_pkg::DEV_W-1:0]  device_write_byte,
   input  wire logic [i2cw_pkg::HOLD_W-1:0] phase_ticks,
   output      i2cw_pkg::result_type       result
);
   import i2cw_pkg::*;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_BITS,
      SEQ_STOP
   } seq_state_type;

   localparam logic [3:0] ACK_SLOT  = 4'd8;
   localparam logic [1:0] LAST_BYTE = 2'd2;
   localparam logic [1:0] START_END = 2'd3;
   localparam logic [1:0] SUB_END   = 2'd2;

   seq_state_type      state_ff, state_in;
   logic [1:0]         sub_ff, sub_in;
   logic [3:0]         bit_ff, bit_in;
   logic [1:0]         byte_ff, byte_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [2:0]         ack_ff, ack_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               rel_ff, rel_in;
   logic               accepted;
   logic               done;
   logic [HOLD_W-1:0]  hold_load;

   assign hold_load = (phase_ticks == '0) ? HOLD_W'(1) : phase_ticks;

   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      hold_in  = hold_ff;
      frame_in = frame_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      rel_in   = rel_ff;
      accepted = 1'b0;
      done     = 1'b0;
      if (step) begin
         if (item.command) begin
            if (state_ff == SEQ_IDLE) begin
               frame_in = {device_write_byte, item.reg_addr, item.reg_data};
               ack_in   = '0;
               state_in = SEQ_START;
               sub_in   = '0;
               bit_in   = '0;
               byte_in  = '0;
               hold_in  = hold_load;
               sda_in   = 1'b1;
               rel_in   = 1'b0;
               accepted = 1'b1;
            end
         end else if (state_ff != SEQ_IDLE) begin
            if (hold_ff > HOLD_W'(1)) begin
               hold_in = hold_ff - HOLD_W'(1);
            end else begin
               hold_in = hold_load;
               unique case (state_ff)
                  SEQ_START: begin
                     if (sub_ff != START_END) begin
                        sub_in = sub_ff + 2'd1;
                        unique case (sub_ff)
                           2'd0:    scl_in = 1'b1;
                           2'd1:    sda_in = 1'b0;
                           default: scl_in = 1'b0;
                        endcase
                     end else begin
                        // first data bit of the device byte
                        state_in = SEQ_BITS;
                        sub_in   = '0;
                        bit_in   = '0;
                        byte_in  = '0;
                        sda_in   = frame_ff[FRAME_W-1];
                        rel_in   = 1'b0;
                        frame_in = {frame_ff[FRAME_W-2:0], 1'b0};
                     end
                  end
                  SEQ_BITS: begin
                     // ack sampled at the end of the SCL-high phase
                     if (bit_ff == ACK_SLOT && sub_ff == 2'd1 && item.sda_in) begin
                        ack_in = ack_ff | (3'b001 << byte_ff);
                     end
                     if (sub_ff != SUB_END) begin
                        sub_in = sub_ff + 2'd1;
                        scl_in = (sub_ff == 2'd0);
                     end else if (bit_ff != ACK_SLOT) begin
                        sub_in = '0;
                        bit_in = bit_ff + 4'd1;
                        if (bit_ff + 4'd1 == ACK_SLOT) begin
                           sda_in = 1'b1;
                           rel_in = 1'b1;
                        end else begin
                           sda_in   = frame_ff[FRAME_W-1];
                           rel_in   = 1'b0;
                           frame_in = {frame_ff[FRAME_W-2:0], 1'b0};
                        end
                     end else if (byte_ff != LAST_BYTE) begin
                        sub_in   = '0;
                        bit_in   = '0;
                        byte_in  = byte_ff + 2'd1;
                        sda_in   = frame_ff[FRAME_W-1];
                        rel_in   = 1'b0;
                        frame_in = {frame_ff[FRAME_W-2:0], 1'b0};
                     end else begin
                        state_in = SEQ_STOP;
                        sub_in   = '0;
                        scl_in   = 1'b0;
                        sda_in   = 1'b0;
                        rel_in   = 1'b0;
                     end
                  end
                  SEQ_STOP: begin
                     if (sub_ff != SUB_END) begin
                        sub_in = sub_ff + 2'd1;
                        if (sub_ff == 2'd0) begin
                           scl_in = 1'b1;
                        end else begin
                           sda_in = 1'b1;
                        end
                     end else begin
                        state_in = SEQ_IDLE;
                        hold_in  = '0;
                        done     = 1'b1;
                     end
                  end
                  default: begin
                     hold_in = hold_ff;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         sub_ff   <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         hold_ff  <= '0;
         frame_ff <= '0;
         ack_ff   <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         rel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         hold_ff  <= hold_in;
         frame_ff <= frame_in;
         ack_ff   <= ack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         rel_ff   <= rel_in;
      end
   end

   always_comb begin
      result.scl_out      = scl_in;
      result.sda_out      = sda_in;
      result.sda_released = rel_in;
      result.busy_res     = (state_in != SEQ_IDLE);
      result.accepted     = accepted;
      result.done_res     = done;
      result.ack_fail     = ack_in;
   end

endmodule
`default_nettype wire

### hw/rtl/i2c_codec_register_writer.sv
// Top level: input register, csr registers, sequencer and result register.
// An input-register word's result word is written into the result register on advance.
// Throughput: one word per cycle unless stalled; sequencer state advances once per word.
// The input register frees when the result register is empty or being taken.
// Reset (synchronous, active high): bus idle with SCL and SDA high, no write
// in progress, ack flags clear, device byte 0x34 and phase hold 900 ticks.
`default_nettype none
module i2c_codec_register_writer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic                       req_command,
   input  wire logic [6:0]                 req_reg_addr,
   input  wire logic [8:0]                 req_reg_data,
   input  wire logic                       req_sda_in,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic                       rsp_scl_out,
   output      logic                       rsp_sda_out,
   output      logic                       rsp_sda_released,
   output      logic                       rsp_busy_res,
   output      logic                       rsp_accepted,
   output      logic                       rsp_done_res,
   output      logic [2:0]                 rsp_ack_fail,
   input  wire logic                       csr_write_enable,
   input  wire logic                       csr_index,
   input  wire logic [i2cw_pkg::CSR_W-1:0] csr_write_data
);
   import i2cw_pkg::*;

   logic              in_valid_ff;
   item_type          item_ff;
   logic              out_valid_ff;
   result_type        result_ff;
   result_type        result_in;
   logic [DEV_W-1:0]  dev_byte_ff;
   logic [HOLD_W-1:0] phase_ticks_ff;
   logic              advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         dev_byte_ff    <= DEV_BYTE_RESET;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEVICE_WRITE_BYTE: dev_byte_ff    <= csr_write_data[DEV_W-1:0];
               CSR_PHASE_TICKS:       phase_ticks_ff <= csr_write_data[HOLD_W-1:0];
               default:               dev_byte_ff    <= dev_byte_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= '{command:  req_command,
                      reg_addr: req_reg_addr,
                      reg_data: req_reg_data,
                      sda_in:   req_sda_in};
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   i2cw_sequencer u_sequencer (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .item              (item_ff),
      .device_write_byte (dev_byte_ff),
      .phase_ticks       (phase_ticks_ff),
      .result            (result_in)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_out      = result_ff.scl_out;
   assign rsp_sda_out      = result_ff.sda_out;
   assign rsp_sda_released = result_ff.sda_released;
   assign rsp_busy_res     = result_ff.busy_res;
   assign rsp_accepted     = result_ff.accepted;
   assign rsp_done_res     = result_ff.done_res;
   assign rsp_ack_fail     = result_ff.ack_fail;

endmodule
`default_nettype wire

### sim/tb_i2c_codec_register_writer.sv
// Self-checking testbench for the I2C codec register writer: bus-phase predictor and scoreboard.
`timescale 1ns / 1ps
module tb_i2c_codec_register_writer;
   import i2cw_pkg::*;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;
   localparam int   STOP_PHASE = 86;
   localparam int   LAST_PHASE = 88;
   localparam int   PHASE_WORDS = 150;

   typedef struct packed {
      logic       command;
      logic [6:0] addr;
      logic [8:0] value;
      logic       sda;
      logic       typed;
      result_type want;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = CMD_TICK;
   logic [6:0]          req_reg_addr = '0;
   logic [8:0]          req_reg_data = '0;
   logic                req_sda_in = 1'b1;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_scl_out;
   logic                rsp_sda_out;
   logic                rsp_sda_released;
   logic                rsp_busy_res;
   logic                rsp_accepted;
   logic                rsp_done_res;
   logic [2:0]          rsp_ack_fail;
   logic                csr_write_enable = 1'b0;
   logic                csr_index = CSR_DEVICE_WRITE_BYTE;
   logic [CSR_W-1:0]    csr_write_data = '0;

   // predicted bus state
   logic [7:0]  cfg_dev = DEV_BYTE_RESET;
   logic [15:0] cfg_ticks = PHASE_TICKS_RESET;
   int          bus_phase = 0;
   logic [15:0] bus_hold = '0;
   logic [23:0] bus_frame = '0;
   logic [2:0]  bus_nack = '0;
   logic        bus_scl = 1'b1;
   logic        bus_sda = 1'b1;
   logic        bus_release = 1'b0;
   logic        bus_active = 1'b0;

   result_type       bus_results[$];
   directed_row_type script[$];
   result_type       got_word;
   result_type       want_word;

   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int writes_started = 0;
   int writes_ignored = 0;
   int stops_seen = 0;
   int nack_bytes = 0;
   int burst_left = 1;
   bit gaps_on = 1'b1;

   i2c_codec_register_writer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_reg_addr     (req_reg_addr),
      .req_reg_data     (req_reg_data),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_sda_released (rsp_sda_released),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_accepted     (rsp_accepted),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_fail     (rsp_ack_fail),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // line changes that open bus phase p
   function automatic void open_phase(int p);
      int q;
      int byte_no;
      int slot;
      bus_phase = p;
      bus_hold  = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
      if (p == 1) begin
         bus_sda = 1'b1;
         bus_release = 1'b0;
      end else if (p == 2) begin
         bus_scl = 1'b1;
      end else if (p == 3) begin
         bus_sda = 1'b0;
      end else if (p == 4) begin
         bus_scl = 1'b0;
      end else if (p < STOP_PHASE) begin
         q = p - 5;
         byte_no = q / 27;
         slot = q % 27;
         if (slot < 24) begin
            case (slot % 3)
               0: begin
                  bus_sda = bus_frame[23 - 8 * byte_no - slot / 3];
                  bus_release = 1'b0;
               end
               1: bus_scl = 1'b1;
               default: bus_scl = 1'b0;
            endcase
         end else begin
            case (slot - 24)
               0: begin
                  bus_sda = 1'b1;
                  bus_release = 1'b1;
               end
               1: bus_scl = 1'b1;
               default: bus_scl = 1'b0;
            endcase
         end
      end else if (p == STOP_PHASE) begin
         bus_scl = 1'b0;
         bus_sda = 1'b0;
         bus_release = 1'b0;
      end else if (p == STOP_PHASE + 1) begin
         bus_scl = 1'b1;
      end else begin
         bus_sda = 1'b1;
      end
   endfunction

   function automatic result_type bus_step(logic command, logic [6:0] addr,
                                           logic [8:0] value, logic sda);
      result_type r;
      int q;
      r = '0;
      if (command == CMD_WRITE) begin
         if (!bus_active) begin
            bus_frame  = {cfg_dev, addr, value[8], value[7:0]};
            bus_nack   = '0;
            bus_active = 1'b1;
            r.accepted = 1'b1;
            open_phase(1);
         end
      end else if (bus_active) begin
         if (bus_hold > 16'd1) begin
            bus_hold = bus_hold - 16'd1;
         end else begin
            // ack sampled at the end of the SCL-high phase of each ack slot
            if (bus_phase >= 5 && bus_phase < STOP_PHASE) begin
               q = bus_phase - 5;
               if (q % 27 == 25 && sda)
                  bus_nack[q / 27] = 1'b1;
            end
            if (bus_phase >= LAST_PHASE) begin
               bus_active = 1'b0;
               bus_phase = 0;
               bus_hold = '0;
               r.done_res = 1'b1;
            end else begin
               open_phase(bus_phase + 1);
            end
         end
      end
      r.scl_out      = bus_scl;
      r.sda_out      = bus_sda;
      r.sda_released = bus_release;
      r.busy_res     = bus_active;
      r.ack_fail     = bus_nack;
      return r;
   endfunction

   // called at a falling edge; returns at a falling edge after the word is taken
   task automatic send_word(logic command, logic [6:0] addr, logic [8:0] value, logic sda,
                            logic typed, result_type want);
      result_type r;
      int gap;
      req_valid    <= 1'b1;
      req_command  <= command;
      req_reg_addr <= addr;
      req_reg_data <= value;
      req_sda_in   <= sda;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      r = bus_step(command, addr, value, sda);
      bus_results.push_back(typed ? want : r);
      words_sent++;
      if (command == CMD_WRITE) begin
         if (r.accepted)
            writes_started++;
         else
            writes_ignored++;
      end
      if (r.done_res) begin
         stops_seen++;
         nack_bytes += int'(bus_nack[0]) + int'(bus_nack[1]) + int'(bus_nack[2]);
      end
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 9) < 4 || !gaps_on) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic tick(logic sda);
      send_word(CMD_TICK, 7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)), sda,
                1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (bus_results.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic index, logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_DEVICE_WRITE_BYTE)
         cfg_dev = data[7:0];
      else
         cfg_ticks = data;
      @(negedge clock);
   endtask

   task automatic setup(logic [7:0] dev, logic [15:0] ticks);
      while (bus_active)
         tick(1'($urandom_range(0, 1)));
      drain();
      csr_write(CSR_DEVICE_WRITE_BYTE, {8'($urandom_range(0, 255)), dev});
      csr_write(CSR_PHASE_TICKS, ticks);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word = {rsp_scl_out, rsp_sda_out, rsp_sda_released, rsp_busy_res,
                     rsp_accepted, rsp_done_res, rsp_ack_fail};
         if (bus_results.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            want_word = bus_results.pop_front();
            check_field("scl_out", int'(want_word.scl_out), int'(got_word.scl_out));
            check_field("sda_out", int'(want_word.sda_out), int'(got_word.sda_out));
            check_field("sda_released", int'(want_word.sda_released),
                        int'(got_word.sda_released));
            check_field("busy_res", int'(want_word.busy_res), int'(got_word.busy_res));
            check_field("accepted", int'(want_word.accepted), int'(got_word.accepted));
            check_field("done_res", int'(want_word.done_res), int'(got_word.done_res));
            check_field("ack_fail", int'(want_word.ack_fail), int'(got_word.ack_fail));
            words_checked++;
         end
      end
   end

   // receiver: own stall pattern, with two long hold-offs
   initial begin
      int cyc;
      int hold;
      int pct;
      cyc = 0;
      hold = 0;
      pct = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 1500 || cyc == 6000)
            hold = 300;
         if (cyc % 50 == 0)
            case ($urandom_range(0, 3))
               0: pct = 0;
               1: pct = 25;
               2: pct = 60;
               default: pct = 90;
            endcase
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [6:0] addr;
      logic [8:0] value;
      int ack_mode;
      int phase_words;
      directed_row_type row;
      logic [7:0] dev_list[6];
      logic [15:0] tick_list[6];

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: device byte all ones, zero hold count (one tick per phase)
      setup(8'hff, 16'd0);
      script.push_back({CMD_TICK, 7'd0, 9'd0, 1'b1, 1'b1,
                        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0});
      script.push_back({CMD_TICK, 7'd127, 9'd511, 1'b0, 1'b1,
                        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0});
      script.push_back({CMD_WRITE, 7'd127, 9'd511, 1'b0, 1'b1,
                        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 3'd0});
      script.push_back({CMD_WRITE, 7'd0, 9'd0, 1'b1, 1'b1,
                        1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0});
      for (int i = 0; i < 20; i++)
         script.push_back({CMD_TICK, 7'd0, 9'd0, 1'(i % 2), 1'b0, 9'd0});
      foreach (script[i]) begin
         row = script[i];
         send_word(row.command, row.addr, row.value, row.sda, row.typed, row.want);
      end

      // random phases
      dev_list  = '{8'h00, 8'hff, DEV_BYTE_RESET, 8'($urandom), 8'($urandom), 8'($urandom)};
      tick_list = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd4, 16'($urandom_range(1, 3))};
      ack_mode = 0;
      for (int s = 0; s < 6; s++) begin
         setup(dev_list[s], tick_list[s]);
         gaps_on = (s != 2);
         phase_words = 0;
         while (phase_words < PHASE_WORDS || bus_active) begin
            if (!bus_active) begin
               if ($urandom_range(0, 9) == 0) begin
                  tick(1'($urandom_range(0, 1)));
               end else begin
                  addr  = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 7'd127 : 7'd0)
                                                       : 7'($urandom_range(0, 127));
                  value = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 9'd511 : 9'd0)
                                                       : 9'($urandom_range(0, 511));
                  ack_mode = $urandom_range(0, 2);
                  send_word(CMD_WRITE, addr, value, 1'($urandom_range(0, 1)), 1'b0, '0);
               end
            end else if ($urandom_range(0, 24) == 0) begin
               send_word(CMD_WRITE, 7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)),
                         1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               tick(ack_mode == 0 ? 1'($urandom_range(0, 1)) : (ack_mode == 2));
            end
            phase_words++;
            if (s == 1 && phase_words == 75)
               drain();
         end
      end

      // longest hold: one write started, a few hundred ticks into its first phase
      gaps_on = 1'b1;
      setup(8'($urandom), 16'hffff);
      send_word(CMD_WRITE, 7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)), 1'b0,
                1'b0, '0);
      repeat (200)
         tick(1'($urandom_range(0, 1)));

      drain();
      repeat (10) @(posedge clock);
      $display("Checked %0d of %0d words over eight csr settings, hold counts 0 to 65535.",
               words_checked, words_sent);
      $display("Writes started %0d, ignored while busy %0d, stops %0d, nacked bytes %0d.",
               writes_started, writes_ignored, stops_seen, nack_bytes);
      if (errors == 0 && bus_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
